### rtl/periodic_task_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core_assert
// Assertion macros for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants of the periodic task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdW   = 5;
  localparam int unsigned ActW  = 3;
  localparam int unsigned KindW = 3;

  localparam logic [CfgW-1:0] DefaultWaitReset = 16'd100;

  typedef enum logic [ActW-1:0] {
    ACT_TICK     = 3'd0,
    ACT_CREATE   = 3'd1,
    ACT_SET_IVAL = 3'd2,
    ACT_PAUSE    = 3'd3,
    ACT_RESUME   = 3'd4,
    ACT_QUERY    = 3'd5
  } action_e;

  typedef enum logic [KindW-1:0] {
    KIND_FIRE      = 3'd0,
    KIND_TICK_DONE = 3'd1,
    KIND_CREATED   = 3'd2,
    KIND_ACK       = 3'd3,
    KIND_ELAPSED   = 3'd4,
    KIND_FULL      = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_CMP,
    ST_T_UPD,
    ST_T_HINT,
    ST_T_DONE,
    ST_C_SCAN,
    ST_C_WR,
    ST_SLOT_RD,
    ST_SLOT_EV
  } state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             borrow;
  } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pts_alu.sv
// ----------------------------------------------------------------------------
// pts_alu
// Shared 32-bit add/subtract unit; borrow doubles as the unsigned compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pts_alu (
  input  wire pts_pkg::alu_req_t req_i,
  output pts_pkg::alu_rsp_t      rsp_o
);
  import pts_pkg::*;

  logic [DataW:0] diff;

  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    case (req_i.op)
      ALU_ADD: begin
        rsp_o.res    = req_i.a + req_i.b;
        rsp_o.borrow = 1'b0;
      end
      ALU_SUB: begin
        rsp_o.res    = diff[DataW-1:0];
        rsp_o.borrow = diff[DataW];  // a < b, unsigned
      end
      default: begin
        rsp_o.res    = '0;
        rsp_o.borrow = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/periodic_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core
// Table of periodic tasks with tick scan, create, set interval, pause,
// resume and elapsed query, run by a small sequencer around one adder.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid / stall   | action, task_id, interval, now
//  out     | output    | out_valid / stall  | kind, id, value, bad_id, last
//  cfg     | input     | cfg_valid / ready  | default_wait_ms (16 bit)
//
//  A tick skips idle and paused slots and steps each running slot through
//  read, compare, re-arm if due and hint update, all on the one shared adder.
//  Create scans one slot per cycle from slot 1 for the first inactive slot.
//  Resume and query read the RAM before their result; set interval and pause do not.
//  Reset clears the per-slot valid bits at once; no clearing pass is needed.
//  A stalled output holds the sequencer only where it has a result to emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_task_scheduler_core_assert.svh"

module periodic_task_scheduler_core #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input transactions
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [pts_pkg::ActW-1:0]    action_i,
  input  wire logic [pts_pkg::IdW-1:0]     task_id_i,
  input  wire logic [pts_pkg::DataW-1:0]   interval_ms_i,
  input  wire logic [pts_pkg::DataW-1:0]   now_ms_i,
  // result transactions
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [pts_pkg::KindW-1:0]   result_kind_o,
  output logic      [pts_pkg::IdW-1:0]     result_id_o,
  output logic      [pts_pkg::DataW-1:0]   result_value_o,
  output logic                             bad_id_o,
  output logic                             last_o,
  // configuration write
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [pts_pkg::CfgW-1:0]    cfg_wdata_i
);
  import pts_pkg::*;

  localparam int unsigned SlotW  = $clog2(SLOT_COUNT);
  localparam int unsigned CntW   = SlotW + 1;
  localparam int unsigned IdExtW = SlotW + IdW + 1;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CntW-1:0]     scan_q, scan_d;      // slot under work
  logic [SlotW-1:0]    idx;
  logic                scan_end;

  action_e             act_q;
  logic                bad_q;
  logic [DataW-1:0]    now_q;
  logic [DataW-1:0]    interval_q;
  logic [DataW-1:0]    tick_time_q;
  logic [DataW-1:0]    hint_q, hint_d;
  logic [DataW-1:0]    cand_q, cand_d;      // wait hint candidate
  logic                ge_q, ge_d;          // now >= deadline
  logic [CfgW-1:0]     default_wait_q;

  logic [SLOT_COUNT-1:0] active_q, paused_q;
  logic [SLOT_COUNT-1:0] lr_vld_q, dl_vld_q, pd_vld_q;
  logic                  lr_v_q, dl_v_q, pd_v_q;
  logic                  active_set, paused_set, paused_clr;

  // table memories
  logic                lr_we, dl_we, pd_we;
  logic [DataW-1:0]    lr_wdata;
  logic [DataW-1:0]    lr_rdata, dl_rdata, pd_rdata;
  logic [DataW-1:0]    lr_rd, dl_rd, pd_rd;

  // shared adder
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  // accept and slot decode
  logic                in_fire;
  logic                in_ok;
  logic [SlotW-1:0]    slot_in;

  // result register
  logic                out_valid_q;
  kind_e               out_kind_q, out_kind_d;
  logic [IdW-1:0]      out_id_q, out_id_d;
  logic [DataW-1:0]    out_value_q, out_value_d;
  logic                out_bad_q, out_bad_d;
  logic                out_last_q, out_last_d;
  logic                out_ld;
  logic                out_busy;
  logic [IdExtW-1:0]   id_ext;

  assign idx      = scan_q[SlotW-1:0];
  assign scan_end = (scan_q == CntW'(SLOT_COUNT));
  assign id_ext   = IdExtW'(scan_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_ok      = (32'(task_id_i) < 32'(SLOT_COUNT));
  assign slot_in    = in_ok ? SlotW'(task_id_i) : '0;

  assign cfg_ready_o = 1'b1;

  // A result that waits and is not taken this cycle blocks a new one.
  assign out_busy = out_valid_q && out_stall_i;

  // never-written entries read as zero
  assign lr_rd = lr_v_q ? lr_rdata : '0;
  assign dl_rd = dl_v_q ? dl_rdata : '0;
  assign pd_rd = pd_v_q ? pd_rdata : '0;

  // --------------------------------------------------------------------------
  // Table memories: last run, deadline, period. Read and write at scan_q.
  // --------------------------------------------------------------------------
  pts_ram #(.Width(DataW), .Depth(SLOT_COUNT)) u_last_run (
    .clk_i  (clk_i),
    .we_i   (lr_we),
    .waddr_i(idx),
    .wdata_i(lr_wdata),
    .raddr_i(idx),
    .rdata_o(lr_rdata)
  );

  pts_ram #(.Width(DataW), .Depth(SLOT_COUNT)) u_deadline (
    .clk_i  (clk_i),
    .we_i   (dl_we),
    .waddr_i(idx),
    .wdata_i(alu_rsp.res),
    .raddr_i(idx),
    .rdata_o(dl_rdata)
  );

  pts_ram #(.Width(DataW), .Depth(SLOT_COUNT)) u_period (
    .clk_i  (clk_i),
    .we_i   (pd_we),
    .waddr_i(idx),
    .wdata_i(interval_q),
    .raddr_i(idx),
    .rdata_o(pd_rdata)
  );

  pts_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    hint_d     = hint_q;
    cand_d     = cand_q;
    ge_d       = ge_q;
    alu_req.op = ALU_ADD;
    alu_req.a  = now_q;
    alu_req.b  = interval_q;
    lr_we      = 1'b0;
    dl_we      = 1'b0;
    pd_we      = 1'b0;
    lr_wdata   = now_q;
    active_set = 1'b0;
    paused_set = 1'b0;
    paused_clr = 1'b0;
    out_ld      = 1'b0;
    out_kind_d  = KIND_ACK;
    out_id_d    = id_ext[IdW-1:0];
    out_value_d = '0;
    out_bad_d   = 1'b0;
    out_last_d  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_e'(action_i))
            ACT_TICK: begin
              scan_d  = CntW'(1);
              hint_d  = DataW'(default_wait_q);
              state_d = ST_T_RD;
            end
            ACT_CREATE: begin
              scan_d  = CntW'(1);
              state_d = ST_C_SCAN;
            end
            ACT_SET_IVAL, ACT_PAUSE: begin
              scan_d  = {1'b0, slot_in};
              state_d = ST_SLOT_EV;
            end
            ACT_RESUME, ACT_QUERY: begin
              scan_d  = {1'b0, slot_in};
              state_d = ST_SLOT_RD;
            end
            default: begin
              state_d = ST_IDLE;  // unknown action: dropped, no result
            end
          endcase
        end
      end

      // tick scan: skip idle and paused slots, read the others
      ST_T_RD: begin
        if (scan_end) begin
          state_d = ST_T_DONE;
        end else if (!active_q[idx] || paused_q[idx]) begin
          scan_d = scan_q + CntW'(1);
        end else begin
          state_d = ST_T_CMP;
        end
      end

      ST_T_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = now_q;
        alu_req.b  = dl_rd;
        ge_d       = !alu_rsp.borrow;
        state_d    = ST_T_UPD;
      end

      ST_T_UPD: begin
        if (ge_q) begin
          if (!out_busy) begin
            // fire and re-arm at now + period
            alu_req.op = ALU_ADD;
            alu_req.a  = now_q;
            alu_req.b  = pd_rd;
            dl_we      = 1'b1;
            lr_we      = 1'b1;
            cand_d     = pd_rd;
            out_ld     = 1'b1;
            out_kind_d = KIND_FIRE;
            out_last_d = 1'b0;
            state_d    = ST_T_HINT;
          end
        end else begin
          alu_req.op = ALU_SUB;
          alu_req.a  = dl_rd;
          alu_req.b  = now_q;
          cand_d     = alu_rsp.res;
          state_d    = ST_T_HINT;
        end
      end

      ST_T_HINT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = cand_q;
        alu_req.b  = hint_q;
        if ((cand_q != '0) && alu_rsp.borrow) begin
          hint_d = cand_q;
        end
        scan_d  = scan_q + CntW'(1);
        state_d = ST_T_RD;
      end

      ST_T_DONE: begin
        if (!out_busy) begin
          out_ld      = 1'b1;
          out_kind_d  = KIND_TICK_DONE;
          out_id_d    = '0;
          out_value_d = hint_q;
          state_d     = ST_IDLE;
        end
      end

      // create: first inactive slot from 1
      ST_C_SCAN: begin
        if (scan_end) begin
          if (!out_busy) begin
            out_ld     = 1'b1;
            out_kind_d = KIND_FULL;
            out_id_d   = '0;
            state_d    = ST_IDLE;
          end
        end else if (!active_q[idx]) begin
          state_d = ST_C_WR;
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end

      ST_C_WR: begin
        if (!out_busy) begin
          alu_req.op = ALU_ADD;
          alu_req.a  = now_q;
          alu_req.b  = interval_q;
          dl_we      = 1'b1;
          lr_we      = 1'b1;
          pd_we      = 1'b1;
          active_set = 1'b1;
          out_ld     = 1'b1;
          out_kind_d = KIND_CREATED;
          state_d    = ST_IDLE;
        end
      end

      ST_SLOT_RD: begin
        state_d = ST_SLOT_EV;
      end

      ST_SLOT_EV: begin
        if (!out_busy) begin
          out_ld    = 1'b1;
          out_bad_d = bad_q;
          state_d   = ST_IDLE;
          case (act_q)
            ACT_SET_IVAL: begin
              alu_req.op = ALU_ADD;
              alu_req.a  = now_q;
              alu_req.b  = interval_q;
              dl_we      = 1'b1;
              pd_we      = 1'b1;
            end
            ACT_PAUSE: begin
              paused_set = 1'b1;
            end
            ACT_RESUME: begin
              alu_req.op = ALU_ADD;
              alu_req.a  = tick_time_q;
              alu_req.b  = pd_rd;
              dl_we      = 1'b1;
              lr_we      = 1'b1;
              lr_wdata   = tick_time_q;
              paused_clr = 1'b1;
            end
            ACT_QUERY: begin
              alu_req.op  = ALU_SUB;
              alu_req.a   = tick_time_q;
              alu_req.b   = lr_rd;
              out_kind_d  = KIND_ELAPSED;
              out_value_d = alu_rsp.res;
            end
            default: begin
              out_ld = 1'b0;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      scan_q         <= '0;
      tick_time_q    <= '0;
      hint_q         <= DataW'(DefaultWaitReset);
      default_wait_q <= DefaultWaitReset;
      active_q       <= '0;
      paused_q       <= '0;
      lr_vld_q       <= '0;
      dl_vld_q       <= '0;
      pd_vld_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      hint_q  <= hint_d;

      if (cfg_valid_i && cfg_ready_o) begin
        default_wait_q <= cfg_wdata_i;
      end

      if (in_fire && (action_i == ACT_TICK)) begin
        tick_time_q <= now_ms_i;
      end

      if (active_set) active_q[idx] <= 1'b1;
      if (paused_set) paused_q[idx] <= 1'b1;
      if (paused_clr) paused_q[idx] <= 1'b0;
      if (lr_we)      lr_vld_q[idx] <= 1'b1;
      if (dl_we)      dl_vld_q[idx] <= 1'b1;
      if (pd_we)      pd_vld_q[idx] <= 1'b1;

      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q      <= action_e'(action_i);
      bad_q      <= !in_ok;
      now_q      <= now_ms_i;
      interval_q <= interval_ms_i;
    end
    cand_q <= cand_d;
    ge_q   <= ge_d;
    // valid bits follow the registered RAM read
    lr_v_q <= lr_vld_q[idx];
    dl_v_q <= dl_vld_q[idx];
    pd_v_q <= pd_vld_q[idx];
    if (out_ld) begin
      out_kind_q  <= out_kind_d;
      out_id_q    <= out_id_d;
      out_value_q <= out_value_d;
      out_bad_q   <= out_bad_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign result_id_o    = out_id_q;
  assign result_value_o = out_value_q;
  assign bad_id_o       = out_bad_q;
  assign last_o         = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PTS_ASSERT_IMP(a_load_only_when_free, clk_i, rst_ni, out_ld, !out_busy)
  `PTS_ASSERT_NXT(a_last_ends_item, clk_i, rst_ni, out_ld && out_last_d, state_q == ST_IDLE)
  `PTS_ASSERT_IMP(a_scan_skips_slot0, clk_i, rst_ni, state_q == ST_T_RD, scan_q != '0)
  `PTS_ASSERT_NXT(a_tick_starts_scan, clk_i, rst_ni,
                  in_fire && (action_i == ACT_TICK), state_q == ST_T_RD)

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for periodic_task_scheduler_core: a scoreboard
// class keeps its own copy of the task table, predicts every result of each
// accepted transaction and checks the result stream in order, while plain
// tasks drive directed and random commands under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pts_pkg::*;

typedef struct {
  kind_e            kind;
  logic [IdW-1:0]   id;
  logic [DataW-1:0] value;
  logic             bad;
  logic             last;
} sched_result_t;

// Shadow task table plus the queue of results still owed by the block.
class sched_scoreboard;
  int unsigned      slot_count;
  bit               active[];
  bit               paused[];
  logic [DataW-1:0] last_run[];
  logic [DataW-1:0] deadline[];
  logic [DataW-1:0] period[];
  logic [DataW-1:0] tick_time;
  logic [DataW-1:0] wait_hint;
  logic [CfgW-1:0]  default_wait;
  sched_result_t    owed_q[$];
  int unsigned      errors;
  int unsigned      n_in;
  int unsigned      n_out;
  int unsigned      n_fire;
  int unsigned      n_full;
  int unsigned      n_cfg;

  function new(int unsigned slots);
    slot_count = slots;
    active     = new[slots];
    paused     = new[slots];
    last_run   = new[slots];
    deadline   = new[slots];
    period     = new[slots];
    for (int s = 0; s < slots; s++) begin
      active[s]   = 1'b0;
      paused[s]   = 1'b0;
      last_run[s] = '0;
      deadline[s] = '0;
      period[s]   = '0;
    end
    tick_time    = '0;
    default_wait = DefaultWaitReset;
    wait_hint    = DataW'(DefaultWaitReset);
  endfunction

  function void set_default_wait(logic [CfgW-1:0] v);
    default_wait = v;
    n_cfg++;
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  // A candidate only ever lowers the hint, and zero is never taken.
  function void offer_hint(logic [DataW-1:0] v);
    if (v != '0 && v < wait_hint) wait_hint = v;
  endfunction

  function void owe(kind_e k, int unsigned id, logic [DataW-1:0] v, logic bad, logic last);
    sched_result_t r;
    r.kind  = k;
    r.id    = IdW'(id);
    r.value = v;
    r.bad   = bad;
    r.last  = last;
    owed_q.push_back(r);
  endfunction

  function void rearm(int unsigned s, logic [DataW-1:0] ival, logic [DataW-1:0] now);
    period[s] = ival;
    offer_hint(ival >> 1);
    deadline[s] = now + ival;
  endfunction

  function void note_input(logic [ActW-1:0] act, logic [IdW-1:0] tid,
                           logic [DataW-1:0] ival, logic [DataW-1:0] now);
    int unsigned slot;
    logic        bad;
    bit          placed;
    n_in++;
    slot   = 32'(tid);
    bad    = 1'b0;
    placed = 1'b0;
    if (32'(tid) >= slot_count) begin
      slot = 0;
      bad  = 1'b1;
    end
    case (act)
      ACT_TICK: begin
        tick_time = now;
        wait_hint = DataW'(default_wait);
        for (int s = 1; s < slot_count; s++) begin
          if (active[s] && !paused[s]) begin
            if (now >= deadline[s]) begin
              owe(KIND_FIRE, s, '0, 1'b0, 1'b0);
              n_fire++;
              last_run[s] = now;
              deadline[s] = now + period[s];
            end
            offer_hint(deadline[s] - now);
          end
        end
        owe(KIND_TICK_DONE, 0, wait_hint, 1'b0, 1'b1);
      end
      ACT_CREATE: begin
        for (int s = 1; s < slot_count; s++) begin
          if (!placed && !active[s]) begin
            active[s]   = 1'b1;
            last_run[s] = now;
            deadline[s] = now;
            rearm(s, ival, now);
            owe(KIND_CREATED, s, '0, 1'b0, 1'b1);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          owe(KIND_FULL, 0, '0, 1'b0, 1'b1);
          n_full++;
        end
      end
      ACT_SET_IVAL: begin
        rearm(slot, ival, now);
        owe(KIND_ACK, slot, '0, bad, 1'b1);
      end
      ACT_PAUSE: begin
        paused[slot] = 1'b1;
        owe(KIND_ACK, slot, '0, bad, 1'b1);
      end
      ACT_RESUME: begin
        paused[slot]   = 1'b0;
        last_run[slot] = tick_time;
        deadline[slot] = tick_time + period[slot];
        owe(KIND_ACK, slot, '0, bad, 1'b1);
      end
      ACT_QUERY: owe(KIND_ELAPSED, slot, tick_time - last_run[slot], bad, 1'b1);
      default: ;
    endcase
  endfunction

  function void check_result(logic [KindW-1:0] kind, logic [IdW-1:0] id,
                             logic [DataW-1:0] value, logic bad, logic last);
    sched_result_t r;
    n_out++;
    if (owed_q.size() == 0) begin
      $error("result with nothing owed: kind %0d id %0d value %0d", kind, id, value);
      errors++;
      return;
    end
    r = owed_q.pop_front();
    if (kind !== r.kind) begin
      $error("result_kind: expected %0d, actual %0d", r.kind, kind);
      errors++;
    end
    if (id !== r.id) begin
      $error("result_id: expected %0d, actual %0d", r.id, id);
      errors++;
    end
    if (value !== r.value) begin
      $error("result_value: expected %0d, actual %0d", r.value, value);
      errors++;
    end
    if (bad !== r.bad) begin
      $error("bad_id: expected %0d, actual %0d", r.bad, bad);
      errors++;
    end
    if (last !== r.last) begin
      $error("last: expected %0d, actual %0d", r.last, last);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int unsigned SlotCount = 32;
  // Settle time, sized for the worst tick with every slot running, plus margin.
  localparam int unsigned SettleCycles = 3 + 4 * SlotCount + 40;
  localparam int unsigned DrainLimit   = 50000;
  localparam int unsigned PhaseItems   = 52;
  // Action codes the block must swallow without a result.
  localparam logic [ActW-1:0] ActSpareLo = 3'd6;
  localparam logic [ActW-1:0] ActSpareHi = 3'd7;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [ActW-1:0]     action_i       = '0;
  logic [IdW-1:0]      task_id_i      = '0;
  logic [DataW-1:0]    interval_ms_i  = '0;
  logic [DataW-1:0]    now_ms_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [KindW-1:0]    result_kind_o;
  logic [IdW-1:0]      result_id_o;
  logic [DataW-1:0]    result_value_o;
  logic                bad_id_o;
  logic                last_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_wdata_i    = '0;

  sched_scoreboard     sb;
  bit                  idle_en = 1'b0;   // random gaps and stalls allowed
  int unsigned         stall_left = 0;
  int unsigned         creates_sent = 0;
  logic [DataW-1:0]    clock_ms = '0;    // running millisecond clock for random commands

  always #5 clk_i = ~clk_i;

  periodic_task_scheduler_core #(
    .SLOT_COUNT(SlotCount)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .task_id_i     (task_id_i),
    .interval_ms_i (interval_ms_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .result_id_o   (result_id_o),
    .result_value_o(result_value_o),
    .bad_id_o      (bad_id_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Result side: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (!idle_en) stall_left = 0;
    else if (stall_left != 0) stall_left--;
    else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
    out_stall_i <= (stall_left != 0);
  end

  // Every accepted result transaction goes straight to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(result_kind_o, result_id_o, result_value_o, bad_id_o, last_o);
  end

  // One command transaction. Valid stays high on return so back-to-back
  // commands never drop it; a gap or close_input() lowers it.
  task automatic send_op(logic [ActW-1:0] act, logic [IdW-1:0] tid,
                         logic [DataW-1:0] ival, logic [DataW-1:0] now);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    task_id_i     <= tid;
    interval_ms_i <= ival;
    now_ms_i      <= now;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, tid, ival, now);
    if (act == ACT_CREATE) creates_sent++;
  endtask

  task automatic close_input();
    in_valid_i <= 1'b0;
  endtask

  // Wait for every owed result, then let a spare item finish in the block.
  task automatic drain();
    int unsigned n;
    n = 0;
    while (sb.pending() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_default_wait(logic [CfgW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_default_wait(v);
  endtask

  // Random command: mostly well-formed traffic on a monotone clock, aimed at
  // slots that exist, with the odd clock jump, huge period or spare code.
  task automatic send_random_op();
    int unsigned      pick;
    int unsigned      hi;
    logic [ActW-1:0]  act;
    logic [IdW-1:0]   tid;
    logic [DataW-1:0] ival;
    logic [DataW-1:0] now;
    pick = $urandom_range(0, 99);
    if      (pick < 34) act = ACT_TICK;
    else if (pick < 52) act = ACT_CREATE;
    else if (pick < 66) act = ACT_SET_IVAL;
    else if (pick < 73) act = ACT_PAUSE;
    else if (pick < 83) act = ACT_RESUME;
    else if (pick < 96) act = ACT_QUERY;
    else act = ($urandom_range(0, 1) == 0) ? ActSpareLo : ActSpareHi;

    hi  = (creates_sent + 1 < SlotCount) ? creates_sent + 1 : SlotCount - 1;
    tid = ($urandom_range(0, 3) != 0) ? IdW'($urandom_range(0, hi)) : IdW'($urandom);

    pick = $urandom_range(0, 99);
    if      (pick < 65) ival = $urandom_range(5, 120);
    else if (pick < 75) ival = '0;
    else if (pick < 85) ival = $urandom_range(1, 4);
    else ival = $urandom;

    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;            // clock jump, may wrap past deadlines
    else clock_ms = clock_ms + $urandom_range(0, 40);
    now = (pick >= 97) ? DataW'($urandom) : clock_ms;

    send_op(act, tid, ival, now);
  endtask

  initial begin
    logic [CfgW-1:0] cfg_plan[4];
    sb = new(SlotCount);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en = 1'b1;

    // Directed: empty table, period zero, wrapping period, pause/resume,
    // slot zero, a top slot never created, spare codes, clock wrap.
    send_op(ACT_QUERY,    5'd0,  $urandom, 32'd0);
    send_op(ACT_TICK,     5'd0,  $urandom, 32'd0);
    send_op(ACT_CREATE,   5'd0,  32'd0, 32'd5);
    send_op(ACT_CREATE,   5'd31, 32'hFFFF_FFFF, 32'd10);
    send_op(ACT_CREATE,   5'd0,  32'd50, 32'd10);
    send_op(ACT_TICK,     5'd31, 32'd0, 32'd10);
    send_op(ACT_SET_IVAL, 5'd3,  32'd20, 32'd15);
    send_op(ACT_PAUSE,    5'd2,  $urandom, $urandom);
    send_op(ACT_TICK,     5'd0,  32'd0, 32'd40);
    send_op(ACT_RESUME,   5'd2,  $urandom, $urandom);
    send_op(ACT_QUERY,    5'd2,  $urandom, $urandom);
    send_op(ACT_QUERY,    5'd3,  $urandom, $urandom);
    send_op(ACT_SET_IVAL, 5'd31, 32'd7, 32'd100);
    send_op(ACT_PAUSE,    5'd31, $urandom, $urandom);
    send_op(ACT_RESUME,   5'd31, $urandom, $urandom);
    send_op(ACT_SET_IVAL, 5'd0,  32'hFFFF_FFFE, 32'd0);
    send_op(ACT_PAUSE,    5'd0,  $urandom, $urandom);
    send_op(ACT_RESUME,   5'd0,  $urandom, $urandom);
    send_op(ACT_QUERY,    5'd0,  $urandom, $urandom);
    send_op(ActSpareLo,   IdW'($urandom), $urandom, $urandom);
    send_op(ActSpareHi,   IdW'($urandom), $urandom, $urandom);
    send_op(ACT_TICK,     5'd0,  32'd0, 32'hFFFF_FFFF);
    send_op(ACT_TICK,     5'd0,  32'd0, 32'd0);
    send_op(ACT_QUERY,    5'd1,  $urandom, $urandom);
    send_op(ACT_QUERY,    5'd31, $urandom, $urandom);
    close_input();
    drain();

    // Random phases, each under its own default wait; the last runs flat out.
    cfg_plan[0] = 16'hFFFF;
    cfg_plan[1] = 16'd1;
    cfg_plan[2] = CfgW'($urandom_range(1, 16'hFFFF));
    cfg_plan[3] = 16'd20;
    clock_ms = 32'd100;
    for (int p = 0; p < 4; p++) begin
      if (p == 3) idle_en = 1'b0;
      write_default_wait(cfg_plan[p]);
      for (int k = 0; k < PhaseItems; k++) send_random_op();
      close_input();
      drain();
    end

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Ran %0d commands and checked %0d results: %0d firings, %0d table-full replies.",
             sb.n_in, sb.n_out, sb.n_fire, sb.n_full);
    $display("Default wait was reprogrammed %0d times, including 1 and 65535.", sb.n_cfg);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/pts_alu.sv
rtl/periodic_task_scheduler_core.sv
test/tb.sv
